@@ design/lpsi_pkg.sv @@
package lpsi_pkg;

    // fraction bits of t
    localparam int FRAC_BITS = 16;

    // sensor level clamp
    localparam logic [6:0] LEVEL_MAX = 7'd100;

    // quadratic terms
    localparam int COEF_W = 12;
    localparam int DISC_W = 22;

    // square root: 16 radicand pairs plus FRAC_BITS extra steps
    localparam int SQ_STEPS = 16 + FRAC_BITS;
    localparam int ROOT_W   = SQ_STEPS;
    localparam int REM_W    = ROOT_W + 2;

    // root numerator and divider
    localparam int NUM_W = FRAC_BITS + 14;
    localparam int DIV_W = NUM_W - 1;
    localparam int DEN_W = 12;

    typedef struct packed {
        logic [6:0] level_0;
        logic [6:0] level_1;
        logic [6:0] level_2;
        logic [6:0] level_3;
        logic [6:0] level_4;
        logic [6:0] level_5;
    } t_in;

    typedef struct packed {
        logic [6:0] line_position;
        logic [2:0] peak_sensor;
        logic [2:0] segment_index;
        logic       root_found;
    } t_out;

    typedef struct packed {
        logic [2:0]               peak;
        logic [2:0]               seg;
        logic signed [COEF_W-1:0] qa;
        logic signed [COEF_W-1:0] qb;
        logic                     real_roots;
    } t_side;

    typedef struct packed {
        logic [2:0]           peak;
        logic [2:0]           seg;
        logic                 found;
        logic [FRAC_BITS-1:0] tq;
    } t_res;

endpackage

@@ design/lpsi_front.sv @@
module lpsi_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  lpsi_pkg::t_in            i_data,
    output logic                     o_valid,
    output lpsi_pkg::t_side          o_side,
    output logic [lpsi_pkg::DISC_W-1:0] o_disc
);

    localparam int CW = lpsi_pkg::COEF_W;

    logic [6:0] lv [6];
    logic [6:0] raw [6];
    logic [6:0] best;
    logic [2:0] pk;
    logic [2:0] sg;
    logic [6:0] p0, p1, p2, p3;
    logic signed [CW-1:0] s0, s1, s2, s3, c1, c2, c3;

    // stage 1 registers
    logic                 r_v1;
    logic [2:0]           r_peak1, r_seg1;
    logic signed [CW-1:0] r_qa, r_qb, r_qc;

    // stage 2
    logic signed [24:0] n_disc;
    logic signed [24:0] sq_b, prod_ac;
    logic               r_v2;
    lpsi_pkg::t_side    r_side;
    logic [lpsi_pkg::DISC_W-1:0] r_disc;

    assign raw[0] = i_data.level_0;
    assign raw[1] = i_data.level_1;
    assign raw[2] = i_data.level_2;
    assign raw[3] = i_data.level_3;
    assign raw[4] = i_data.level_4;
    assign raw[5] = i_data.level_5;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            lv[i] = (raw[i] > lpsi_pkg::LEVEL_MAX) ? lpsi_pkg::LEVEL_MAX : raw[i];
        end
        // first strongest wins
        best = 7'd0;
        pk   = 3'd0;
        for (int i = 0; i < 6; i++) begin
            if (lv[i] > best) begin
                best = lv[i];
                pk   = 3'(i);
            end
        end
    end

    always_comb begin
        sg = pk;
        p0 = lv[0];
        p1 = lv[0];
        p2 = lv[1];
        p3 = lv[2];
        case (pk)
            3'd0, 3'd1: begin
                if (pk == 3'd1 && lv[0] > lv[2]) begin
                    sg = 3'd0;
                end
            end
            3'd2: begin
                if (lv[1] < lv[3]) begin
                    p0 = lv[1]; p1 = lv[2]; p2 = lv[3]; p3 = lv[4];
                end else begin
                    p0 = lv[0]; p1 = lv[1]; p2 = lv[2]; p3 = lv[3];
                    sg = 3'd1;
                end
            end
            3'd3: begin
                if (lv[2] < lv[4]) begin
                    p0 = lv[2]; p1 = lv[3]; p2 = lv[4]; p3 = lv[5];
                end else begin
                    p0 = lv[1]; p1 = lv[2]; p2 = lv[3]; p3 = lv[4];
                    sg = 3'd2;
                end
            end
            3'd4, 3'd5: begin
                p0 = lv[3]; p1 = lv[4]; p2 = lv[5]; p3 = lv[5];
            end
            default: begin
                sg = 3'd0;
            end
        endcase
    end

    assign s0 = signed'({5'd0, p0});
    assign s1 = signed'({5'd0, p1});
    assign s2 = signed'({5'd0, p2});
    assign s3 = signed'({5'd0, p3});
    assign c1 = s2 - s0;
    assign c2 = (s0 <<< 1) - (s1 <<< 2) - s1 + (s2 <<< 2) - s3;
    assign c3 = s3 - s0 + (s1 <<< 1) + s1 - (s2 <<< 1) - s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_peak1 <= pk;
            r_seg1  <= sg;
            r_qa    <= (c3 <<< 1) + c3;
            r_qb    <= c2 <<< 1;
            r_qc    <= c1;
        end
    end

    assign sq_b    = r_qb * r_qb;
    assign prod_ac = r_qa * r_qc;
    assign n_disc  = sq_b - (prod_ac <<< 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side.peak       <= r_peak1;
            r_side.seg        <= r_seg1;
            r_side.qa         <= r_qa;
            r_side.qb         <= r_qb;
            r_side.real_roots <= (r_qa != '0) && !n_disc[24];
            r_disc            <= n_disc[lpsi_pkg::DISC_W-1:0];
        end
    end

    assign o_valid = r_v2;
    assign o_side  = r_side;
    assign o_disc  = r_disc;

endmodule

@@ design/lpsi_sqrt.sv @@
module lpsi_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  lpsi_pkg::t_side             i_side,
    input  logic [lpsi_pkg::DISC_W-1:0] i_disc,
    output logic                        o_valid,
    output lpsi_pkg::t_side             o_side,
    output logic [lpsi_pkg::ROOT_W-1:0] o_root
);

    localparam int N  = lpsi_pkg::SQ_STEPS;
    localparam int RW = lpsi_pkg::ROOT_W;
    localparam int MW = lpsi_pkg::REM_W;

    logic            r_v    [N];
    lpsi_pkg::t_side r_side [N];
    logic [31:0]     r_d    [N];
    logic [MW-1:0]   r_rem  [N];
    logic [RW-1:0]   r_root [N];

    for (genvar k = 0; k < N; k++) begin : g_step
        logic            v_in;
        lpsi_pkg::t_side side_in;
        logic [31:0]     d_in;
        logic [MW-1:0]   rem_in, rem_sh, trial;
        logic [RW-1:0]   root_in;
        logic [1:0]      pair;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign side_in = i_side;
            assign d_in    = 32'(i_disc);
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign side_in = r_side[k-1];
            assign d_in    = r_d[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end

        // two radicand bits per step, zeros once the disc is used up
        if (k < 16) begin : g_pair
            assign pair = d_in[31-2*k -: 2];
        end else begin : g_zero
            assign pair = 2'b00;
        end

        assign rem_sh = {rem_in[MW-3:0], pair};
        assign trial  = {root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= side_in;
                r_d[k]    <= d_in;
                if (rem_sh >= trial) begin
                    r_rem[k]  <= rem_sh - trial;
                    r_root[k] <= {root_in[RW-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= rem_sh;
                    r_root[k] <= {root_in[RW-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_side  = r_side[N-1];
    assign o_root  = r_root[N-1];

endmodule

@@ design/lpsi_root.sv @@
module lpsi_root (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  lpsi_pkg::t_side             i_side,
    input  logic [lpsi_pkg::ROOT_W-1:0] i_root,
    output logic                        o_valid,
    output lpsi_pkg::t_res              o_res
);

    localparam int F  = lpsi_pkg::FRAC_BITS;
    localparam int NW = lpsi_pkg::NUM_W;
    localparam int DW = lpsi_pkg::DIV_W;
    localparam int EW = lpsi_pkg::DEN_W;

    logic signed [NW-1:0] mb, sv, n1, n2, lim, nsel, nabs;
    logic [lpsi_pkg::COEF_W-1:0] aabs;
    logic pos, ok1, ok2;

    assign mb   = -(NW'(i_side.qb) <<< F);
    assign sv   = NW'(i_root);
    assign n1   = mb + sv;
    assign n2   = mb - sv;
    assign lim  = NW'(i_side.qa) <<< (F + 1);
    assign pos  = !i_side.qa[lpsi_pkg::COEF_W-1];
    assign ok1  = i_side.real_roots && (pos ? (n1 > 0 && n1 < lim) : (n1 < 0 && n1 > lim));
    assign ok2  = i_side.real_roots && (pos ? (n2 > 0 && n2 < lim) : (n2 < 0 && n2 > lim));
    assign nsel = ok1 ? n1 : n2;
    assign nabs = nsel[NW-1] ? -nsel : nsel;
    assign aabs = pos ? i_side.qa : -i_side.qa;

    // select stage
    logic          r_v0;
    logic [2:0]    r_peak0, r_seg0;
    logic          r_found0;
    logic [DW-1:0] r_num0;
    logic [EW-1:0] r_den0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_peak0  <= i_side.peak;
            r_seg0   <= i_side.seg;
            r_found0 <= ok1 || ok2;
            r_num0   <= nabs[DW-1:0];
            r_den0   <= {aabs[EW-2:0], 1'b0};
        end
    end

    // restoring divider, one quotient bit per stage
    logic          r_v    [F];
    logic [2:0]    r_peak [F];
    logic [2:0]    r_seg  [F];
    logic          r_fnd  [F];
    logic [DW-1:0] r_rem  [F];
    logic [EW-1:0] r_den  [F];
    logic [F-1:0]  r_q    [F];

    for (genvar j = 0; j < F; j++) begin : g_div
        logic          v_in, f_in;
        logic [2:0]    pk_in, sg_in;
        logic [DW-1:0] rem_in, sh;
        logic [EW-1:0] den_in;
        logic [F-1:0]  q_in;
        logic          ge;

        if (j == 0) begin : g_first
            assign v_in   = r_v0;
            assign f_in   = r_found0;
            assign pk_in  = r_peak0;
            assign sg_in  = r_seg0;
            assign rem_in = r_num0;
            assign den_in = r_den0;
            assign q_in   = '0;
        end else begin : g_next
            assign v_in   = r_v[j-1];
            assign f_in   = r_fnd[j-1];
            assign pk_in  = r_peak[j-1];
            assign sg_in  = r_seg[j-1];
            assign rem_in = r_rem[j-1];
            assign den_in = r_den[j-1];
            assign q_in   = r_q[j-1];
        end

        assign sh = DW'(den_in) << (F - 1 - j);
        assign ge = rem_in >= sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_fnd[j]  <= f_in;
                r_peak[j] <= pk_in;
                r_seg[j]  <= sg_in;
                r_den[j]  <= den_in;
                r_rem[j]  <= ge ? rem_in - sh : rem_in;
                r_q[j]    <= {q_in[F-2:0], ge};
            end
        end
    end

    assign o_valid     = r_v[F-1];
    assign o_res.peak  = r_peak[F-1];
    assign o_res.seg   = r_seg[F-1];
    assign o_res.found = r_fnd[F-1];
    assign o_res.tq    = r_fnd[F-1] ? r_q[F-1] : '0;

endmodule

@@ design/line_position_spline_interp.sv @@
// Line position from six sensor levels by Catmull-Rom peak interpolation.
// One request (six 7-bit levels, clamped to 100) can enter every clock cycle
// while o_stall is low. The pipeline runs through the front end, the
// digit-by-digit square root (one step per stage), a select stage, the
// restoring divider that forms the fraction (one quotient bit per stage)
// and the output register. The whole pipeline advances together: when the
// output register holds a result and the consumer stalls, o_stall rises and
// every stage holds. The result gives the peak sensor, the corrected segment,
// whether a root strictly inside 0..1 was found, and
// floor(20 * (segment + t)).
module line_position_spline_interp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  lpsi_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output lpsi_pkg::t_out o_data
);

    localparam int F = lpsi_pkg::FRAC_BITS;

    logic en;

    logic                        fr_valid;
    lpsi_pkg::t_side             fr_side;
    logic [lpsi_pkg::DISC_W-1:0] fr_disc;

    logic                        sq_valid;
    lpsi_pkg::t_side             sq_side;
    logic [lpsi_pkg::ROOT_W-1:0] sq_root;

    logic           rt_valid;
    lpsi_pkg::t_res rt_res;

    logic [F+4:0]   tq20;
    lpsi_pkg::t_out n_out;
    lpsi_pkg::t_out r_out;
    logic           r_out_valid;

    // advance whenever the output register is free or being taken
    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;

    lpsi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_valid (fr_valid),
        .o_side  (fr_side),
        .o_disc  (fr_disc)
    );

    lpsi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fr_valid),
        .i_side  (fr_side),
        .i_disc  (fr_disc),
        .o_valid (sq_valid),
        .o_side  (sq_side),
        .o_root  (sq_root)
    );

    lpsi_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_side  (sq_side),
        .i_root  (sq_root),
        .o_valid (rt_valid),
        .o_res   (rt_res)
    );

    // 20 * tq as 16*tq + 4*tq; the top bits give the in-segment offset
    assign tq20 = {rt_res.tq, 4'b0000} + {2'b00, rt_res.tq, 2'b00};

    always_comb begin
        n_out.line_position = 7'({rt_res.seg, 4'b0000} + {2'b00, rt_res.seg, 2'b00})
                            + 7'(tq20[F+4:F]);
        n_out.peak_sensor   = rt_res.peak;
        n_out.segment_index = rt_res.seg;
        n_out.root_found    = rt_res.found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= rt_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.line_position <= 7'd119)
        else $error("line position out of range");

    a_seg_le_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.segment_index <= o_data.peak_sensor)
        else $error("segment beyond peak sensor");

    a_no_root_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.root_found) |->
            o_data.line_position == 7'(o_data.segment_index) * 7'd20)
        else $error("fraction without a root");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled result changed");

endmodule
